// File: hw/rtl/pcl_pkg.sv
// Shared types, constants and the microcode ROM for the PWM command line parser.
package pcl_pkg;

   // Character codes
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_F_UP   = 8'h46;
   localparam logic [7:0] CHAR_F_LOW  = 8'h66;
   localparam logic [7:0] CHAR_D_UP   = 8'h44;
   localparam logic [7:0] CHAR_D_LOW  = 8'h64;

   // Widths of the datapath
   localparam int CLOCK_W = 26;
   localparam int FREQ_W  = 13;
   localparam int DUTY_W  = 10;
   localparam int PSC_W   = 16;
   localparam int DIV_W   = 23;   // frequency * 1000 stays below 2^23
   localparam int ACC_W   = 32;
   localparam int CNT_W   = 5;

   // Limits and reset values
   localparam logic [FREQ_W-1:0]  FREQ_MAX      = 13'd8000;
   localparam logic [FREQ_W-1:0]  FREQ_MIN      = 13'd1;
   localparam logic [FREQ_W-1:0]  FREQ_RESET    = 13'd1000;
   localparam logic [DUTY_W-1:0]  DUTY_MAX      = 10'd1000;
   localparam logic [DUTY_W-1:0]  DUTY_RESET    = 10'd500;
   localparam logic [9:0]         PERIOD_COUNTS = 10'd1000;
   localparam logic [PSC_W-1:0]   PSC_MAX       = 16'hFFFF;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 26'd8000000;
   localparam logic [CNT_W-1:0]   DIV_STEPS     = 5'd26;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_FREQ    = 2'd0,
      STATUS_DUTY    = 2'd1,
      STATUS_UNKNOWN = 2'd2
   } status_type;

   // Datapath operations driven by one control word
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LATCH,
      OP_CHAR,
      OP_APPLY,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_EMIT
   } op_type;

   // Jump conditions; the jump is taken when the condition holds
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQUEST,
      COND_NO_ACTION,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT     = 3'd0;
   localparam step_type STEP_CHAR     = 3'd1;
   localparam step_type STEP_APPLY    = 3'd2;
   localparam step_type STEP_DIV_LOAD = 3'd3;
   localparam step_type STEP_DIV      = 3'd4;
   localparam step_type STEP_EMIT     = 3'd5;
   localparam step_type STEP_DONE     = 3'd6;

   typedef struct packed {
      logic     ready;
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Microcode program
   function automatic ctrl_word_type rom_word(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_WAIT:     w = '{1'b1, OP_LATCH,    COND_NO_REQUEST, STEP_WAIT};
         STEP_CHAR:     w = '{1'b0, OP_CHAR,     COND_NO_ACTION,  STEP_WAIT};
         STEP_APPLY:    w = '{1'b0, OP_APPLY,    COND_NEVER,      STEP_WAIT};
         STEP_DIV_LOAD: w = '{1'b0, OP_DIV_LOAD, COND_NEVER,      STEP_WAIT};
         STEP_DIV:      w = '{1'b0, OP_DIV_STEP, COND_DIV_MORE,   STEP_DIV};
         STEP_EMIT:     w = '{1'b0, OP_EMIT,     COND_OUT_BUSY,   STEP_EMIT};
         STEP_DONE:     w = '{1'b0, OP_NONE,     COND_ALWAYS,     STEP_WAIT};
         default:       w = '{1'b0, OP_NONE,     COND_ALWAYS,     STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/pwm_command_line_parser.sv
// Top level of the PWM command line parser: microcode sequencer and its datapath.
//
// Usage: each request on req_ carries one received serial byte. Bytes build a
// command line of up to LINE_CHARS characters (extra ones are dropped). A CR
// or LF ending a non-empty line whose later characters are all digits acts on
// the line and produces one result on rsp_: status in rsp_tuser, applied
// frequency, duty and timer prescaler in rsp_tdata. Other lines produce none.
// csr_wr_en/csr_wr_data load the timer clock frequency in hertz.
//
// Steps: an ordinary character passes the character step and returns to the
// wait step, where the next request can be taken. A line end that acts then
// passes the apply and divider-load steps, the 26 iterations of the
// one-bit-per-cycle prescaler divider, the emit step that raises rsp_tvalid
// and the done step. A line end that does not act returns like a character.
// The result sits in an output register; if the receiver stalls, the sequencer
// waits in its emit step until the earlier result is taken.
// Reset: line state cleared, frequency 1000 Hz, duty 500, clock 8 MHz, and
// the sequencer starts at its wait step with no result pending.
module pwm_command_line_parser #(
   parameter int LINE_CHARS = 15
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [pcl_pkg::CLOCK_W-1:0] csr_wr_data,   // core_clock_hz
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,                     // [7:0] rx_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [12:0] frequency_hz, [22:13] duty_permille,
                                    // [38:23] prescaler, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import pcl_pkg::*;

   localparam int LEN_W = $clog2(LINE_CHARS + 1);
   localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_CHARS);

   // Sequencer
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          jump;

   // Datapath registers
   logic [CLOCK_W-1:0] clock_hz_ff, clock_hz_in;
   logic [7:0]         byte_ff, byte_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [7:0]         letter_ff, letter_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               bad_ff, bad_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   status_type         status_ff, status_in;
   logic [DIV_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [CLOCK_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   // Helpers
   logic               line_end;
   logic               is_digit;
   logic               req_fire;
   logic               out_busy;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     trial_diff;
   logic [ACC_W-1:0]   acc_next;
   logic [PSC_W-1:0]   psc;
   logic [CLOCK_W-1:0] quot_m1;
   logic [FREQ_W-1:0]  freq_cmd;
   logic [DUTY_W-1:0]  duty_cmd;

   assign cw         = rom_word(step_ff);
   assign req_tready = cw.ready;
   assign req_fire   = req_tvalid & cw.ready;
   assign out_busy   = rsp_valid_ff & ~rsp_tready;
   assign line_end   = (byte_ff == CHAR_CR) || (byte_ff == CHAR_LF);
   assign is_digit   = (byte_ff >= CHAR_ZERO) && (byte_ff <= CHAR_NINE);
   assign acc_next   = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(byte_ff - CHAR_ZERO);
   assign trial      = {rem_ff, quot_ff[CLOCK_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign quot_m1    = quot_ff - CLOCK_W'(1);

   // Clamp the accumulated value for each command
   always_comb begin
      if (acc_ff == '0) begin
         freq_cmd = FREQ_MIN;
      end else if (acc_ff > ACC_W'(FREQ_MAX)) begin
         freq_cmd = FREQ_MAX;
      end else begin
         freq_cmd = acc_ff[FREQ_W-1:0];
      end
      if (acc_ff > ACC_W'(DUTY_MAX)) begin
         duty_cmd = DUTY_MAX;
      end else begin
         duty_cmd = acc_ff[DUTY_W-1:0];
      end
   end

   // Prescaler from the quotient: at least one, minus one, capped
   always_comb begin
      if (quot_ff == '0) begin
         psc = '0;
      end else if (quot_m1 > CLOCK_W'(PSC_MAX)) begin
         psc = PSC_MAX;
      end else begin
         psc = quot_m1[PSC_W-1:0];
      end
   end

   // Evaluate the jump condition and pick the next step
   always_comb begin
      case (cw.cond)
         COND_NEVER:      jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_NO_REQUEST: jump = ~req_tvalid;
         COND_NO_ACTION:  jump = ~line_end || (len_ff == '0) || bad_ff;
         COND_DIV_MORE:   jump = (cnt_ff != CNT_W'(1));
         COND_OUT_BUSY:   jump = out_busy;
         default:         jump = 1'b1;
      endcase
      step_in = jump ? cw.target : step_type'(step_ff + step_type'(1));
   end

   // Datapath operations
   always_comb begin
      clock_hz_in = csr_wr_en ? csr_wr_data : clock_hz_ff;
      byte_in     = byte_ff;
      len_in      = len_ff;
      letter_in   = letter_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;
      freq_in     = freq_ff;
      duty_in     = duty_ff;
      status_in   = status_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      cnt_in      = cnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (cw.op)
         OP_LATCH: begin
            if (req_fire) begin
               byte_in = req_tdata;
            end
         end
         OP_CHAR: begin
            if (!line_end) begin
               // Store the character while the line has room
               if (len_ff < LINE_MAX) begin
                  if (len_ff == '0) begin
                     letter_in = byte_ff;
                  end else if (is_digit) begin
                     acc_in = acc_next;
                  end else begin
                     bad_in = 1'b1;
                  end
                  len_in = len_ff + LEN_W'(1);
               end
            end else if ((len_ff == '0) || bad_ff) begin
               // Drop the line without a result
               len_in    = '0;
               letter_in = '0;
               acc_in    = '0;
               bad_in    = 1'b0;
            end
         end
         OP_APPLY: begin
            if ((letter_ff == CHAR_F_UP) || (letter_ff == CHAR_F_LOW)) begin
               freq_in   = freq_cmd;
               status_in = STATUS_FREQ;
            end else if ((letter_ff == CHAR_D_UP) || (letter_ff == CHAR_D_LOW)) begin
               duty_in   = duty_cmd;
               status_in = STATUS_DUTY;
            end else begin
               status_in = STATUS_UNKNOWN;
            end
            len_in    = '0;
            letter_in = '0;
            acc_in    = '0;
            bad_in    = 1'b0;
         end
         OP_DIV_LOAD: begin
            divisor_in = DIV_W'(freq_ff) * DIV_W'(PERIOD_COUNTS);
            rem_in     = '0;
            quot_in    = clock_hz_ff;
            cnt_in     = DIV_STEPS;
         end
         OP_DIV_STEP: begin
            // One restoring division step
            if (!trial_diff[DIV_W]) begin
               rem_in  = trial_diff[DIV_W-1:0];
               quot_in = {quot_ff[CLOCK_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[DIV_W-1:0];
               quot_in = {quot_ff[CLOCK_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, psc, duty_ff, freq_ff};
               rsp_user_in  = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         clock_hz_ff  <= CLOCK_RESET;
         len_ff       <= '0;
         letter_ff    <= '0;
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         freq_ff      <= FREQ_RESET;
         duty_ff      <= DUTY_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         step_ff      <= step_in;
         clock_hz_ff  <= clock_hz_in;
         len_ff       <= len_in;
         letter_ff    <= letter_in;
         acc_ff       <= acc_in;
         bad_ff       <= bad_in;
         freq_ff      <= freq_in;
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      status_ff   <= status_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: dv/pwm_command_line_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the PWM command line parser: byte stimulus, line prediction, checks.
module pwm_command_line_parser_tb;
   import pcl_pkg::*;

   localparam int LINE_CHARS   = 15;
   localparam int DRAIN_CYCLES = 40;        // covers an acting line end
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_BYTES = 490;       // per idling phase

   // One applied setting as reported on the result channel
   typedef struct {
      status_type        status;
      logic [FREQ_W-1:0] frequency;
      logic [DUTY_W-1:0] duty;
      logic [PSC_W-1:0]  prescaler;
   } pwm_setting_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CLOCK_W-1:0]  csr_wr_data = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;    // [7:0] rx_byte
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;         // [12:0] frequency_hz, [22:13] duty_permille,
                                           // [38:23] prescaler, [39] zero
   logic [1:0]          rsp_tuser;         // [1:0] status

   // Predicted parser state
   int                  line_len;
   logic [7:0]          cmd_letter;
   logic [31:0]         value_acc;
   logic                bad_char_seen;
   logic [FREQ_W-1:0]   cur_frequency;
   logic [DUTY_W-1:0]   cur_duty;
   logic [CLOCK_W-1:0]  core_clock;

   pwm_setting_type     pending_settings[$];
   int                  mismatch_count = 0;
   int                  bytes_sent = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  hold_request = 0;
   int                  hold_left = 0;

   pwm_command_line_parser #(.LINE_CHARS(LINE_CHARS)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // Clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   // Derive the timer prescaler for a frequency at the current core clock
   function automatic logic [PSC_W-1:0] prescaler_for(input logic [FREQ_W-1:0] freq);
      logic [63:0] q;
      q = {38'b0, core_clock} / ({51'b0, freq} * 64'd1000);
      if (q < 64'd1) q = 64'd1;
      q = q - 64'd1;
      if (q > 64'd65535) q = 64'd65535;
      return q[PSC_W-1:0];
   endfunction

   function automatic void clear_line();
      line_len      = 0;
      cmd_letter    = '0;
      value_acc     = '0;
      bad_char_seen = 1'b0;
   endfunction

   // Advance the predicted parser by one accepted byte; queue a setting on an acting line end
   function automatic void parse_char(input logic [7:0] ch);
      pwm_setting_type s;
      logic [31:0]     v;
      if (ch != CHAR_CR && ch != CHAR_LF) begin
         if (line_len < LINE_CHARS) begin
            if (line_len == 0)
               cmd_letter = ch;
            else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
               value_acc = value_acc * 32'd10 + {24'b0, ch - CHAR_ZERO};
            else
               bad_char_seen = 1'b1;
            line_len++;
         end
         return;
      end
      if (line_len != 0 && !bad_char_seen) begin
         v = value_acc;
         if (cmd_letter == CHAR_F_UP || cmd_letter == CHAR_F_LOW) begin
            if (v == 32'd0) v = 32'd1;
            if (v > 32'd8000) v = 32'd8000;
            cur_frequency = v[FREQ_W-1:0];
            s.status = STATUS_FREQ;
         end else if (cmd_letter == CHAR_D_UP || cmd_letter == CHAR_D_LOW) begin
            if (v > 32'd1000) v = 32'd1000;
            cur_duty = v[DUTY_W-1:0];
            s.status = STATUS_DUTY;
         end else begin
            s.status = STATUS_UNKNOWN;
         end
         s.frequency = cur_frequency;
         s.duty      = cur_duty;
         s.prescaler = prescaler_for(cur_frequency);
         pending_settings.push_back(s);
      end
      clear_line();
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Compare each taken result with the oldest predicted setting
   always @(posedge clock) begin : check_results
      pwm_setting_type s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_settings.size() == 0) begin
            report_mismatch("unexpected result, frequency", rsp_tdata[12:0], -1);
         end else begin
            s = pending_settings.pop_front();
            if (rsp_tuser != s.status)
               report_mismatch("status", rsp_tuser, s.status);
            if (rsp_tdata[12:0] != s.frequency)
               report_mismatch("frequency_hz", rsp_tdata[12:0], s.frequency);
            if (rsp_tdata[22:13] != s.duty)
               report_mismatch("duty_permille", rsp_tdata[22:13], s.duty);
            if (rsp_tdata[38:23] != s.prescaler)
               report_mismatch("prescaler", rsp_tdata[38:23], s.prescaler);
            if (rsp_tdata[39] != 1'b0)
               report_mismatch("pad bit", rsp_tdata[39], 0);
         end
      end
   end

   // Drive result ready: long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Send one byte; called and returning at a falling edge
   task automatic send_char(input logic [7:0] ch);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      parse_char(ch);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(input string body, input logic [7:0] line_end);
      for (int i = 0; i < body.len(); i++) send_char(body[i]);
      send_char(line_end);
   endtask

   // Drop valid and wait until every predicted setting has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_settings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_core_clock(input logic [CLOCK_W-1:0] hz);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hz;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      core_clock  = hz;
      @(negedge clock);
   endtask

   task automatic test_empty_lines();
      send_char(CHAR_CR);
      send_char(CHAR_LF);
      send_line("F250", CHAR_CR);
      send_char(CHAR_LF);
   endtask

   task automatic test_clamps();
      send_line("F0", CHAR_LF);
      send_line("f99999", CHAR_CR);
      send_line("D1001", CHAR_LF);
      send_line("d0", CHAR_CR);
      send_line("F", CHAR_CR);
   endtask

   task automatic test_unknown_and_bad();
      send_line("X7", CHAR_CR);
      send_line("F1a", CHAR_LF);
      send_line("Q-", CHAR_CR);
      send_line("D", CHAR_LF);
   endtask

   // Overlong lines: drop the tail, act on the held part, wrap the value
   task automatic test_long_line();
      send_line("D12345678901234999", CHAR_CR);
      send_line("F00000000007999x", CHAR_LF);
   endtask

   task automatic test_clock_extremes();
      write_core_clock('0);
      send_line("F1", CHAR_CR);
      write_core_clock(26'd1000);
      send_line("Z", CHAR_LF);
      write_core_clock(26'd48000000);
      send_line("F8000", CHAR_CR);
      send_line("F1", CHAR_CR);
      write_core_clock({CLOCK_W{1'b1}});
      send_line("Z", CHAR_CR);
      send_line("F2", CHAR_LF);
   endtask

   // Hold the receiver off while lines keep coming, so the input stalls
   task automatic test_backpressure();
      drain();
      @(posedge clock);
      hold_request = 300;
      @(negedge clock);
      repeat (6) send_line("F1234", CHAR_CR);
      send_line("d77", CHAR_LF);
      drain();
   endtask

   // Mostly well-formed command lines with random content, some noise and broken lines
   task automatic send_random_line();
      int          kind;
      int          ndigits;
      logic [7:0]  letter;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
         return;
      end
      if (kind < 12) begin
         send_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
         return;
      end
      case ($urandom_range(9))
         0, 1:    letter = CHAR_F_UP;
         2, 3:    letter = CHAR_F_LOW;
         4, 5:    letter = CHAR_D_UP;
         6, 7:    letter = CHAR_D_LOW;
         default: letter = 8'($urandom_range(0, 255));
      endcase
      ndigits = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      send_char(letter);
      repeat (ndigits) begin
         if ($urandom_range(99) < 4)
            send_char(8'($urandom_range(0, 255)));
         else
            send_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      send_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic test_random(input int send_pct, input int recv_pct);
      int target;
      write_core_clock(26'($urandom_range(1000, 48000000)));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) send_random_line();
   endtask

   initial begin
      clear_line();
      cur_frequency = FREQ_RESET;
      cur_duty      = DUTY_RESET;
      core_clock    = CLOCK_RESET;
      send_idle_pct = 36;
      recv_idle_pct = 66;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_lines();
      test_clamps();
      test_unknown_and_bad();
      test_long_line();
      test_clock_extremes();
      test_backpressure();
      test_random(36, 66);
      test_random(66, 36);
      test_random(0, 0);
      drain();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
